// ----- rtl/cpsd_pkg.sv -----
package cpsd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_FLAT_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_MODE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PIC_WIDTH   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PIC_HEIGHT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_RIGHT  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_BOTTOM = 3'd7;

  localparam logic [7:0]  END_MARK       = 8'd255;
  localparam logic [15:0] SCREEN_ROWS    = 16'd200;
  localparam logic [9:0]  CLIP_RIGHT_RST = 10'd320;
  localparam logic [9:0]  CLIP_BOT_RST   = 10'd200;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_LENGTH = 6'b000010,
    PH_PAD    = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_TAIL   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] column_index;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_color;
  } out_beat_t;

endpackage

// ----- rtl/column_post_sprite_decoder_core.sv -----
// Column-post sprite decoder core.
// Input channel (in_valid_i / in_stall_o / in_beat_i) carries one stream byte
// per beat with its picture column and a first-byte mark. Output channel
// (out_valid_o / out_stall_i / out_beat_o) carries frame buffer writes:
// 16-bit byte address and 8-bit palette index. A byte gives zero or one write.
// Config registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must write them only while the block is idle; the block does not enforce it.
// Each byte is captured in an input register, then decoded combinationally
// (post parser step, clip compares and one address multiply-add) into the
// output register, which presents the write.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more byte; further bytes are stalled until
// the output drains.
// Reset returns the config registers to their defaults (patch mode,
// centering on, clip at 320/200), puts the parser at expect-start-row,
// zeroes the flat position and empties both registers.
module column_post_sprite_decoder_core #(
  parameter int unsigned SCREEN_PITCH = 320,
  parameter int unsigned FLAT_SIDE    = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cpsd_pkg::in_beat_t           in_beat_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cpsd_pkg::out_beat_t          out_beat_o,
  input  logic                         cfg_we_i,
  input  logic [cpsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cpsd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned ColW = $clog2(FLAT_SIDE);
  localparam int unsigned RowW = $clog2(FLAT_SIDE + 1);
  localparam logic [15:0] Pitch = 16'(SCREEN_PITCH);

  // config
  logic              flat_mode_q, center_mode_q;
  logic [9:0]        origin_x_q, origin_y_q;
  logic [8:0]        pic_width_q;
  logic [9:0]        pic_height_q, clip_right_q, clip_bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_mode_q   <= 1'b0;
      center_mode_q <= 1'b1;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      pic_width_q   <= '0;
      pic_height_q  <= '0;
      clip_right_q  <= cpsd_pkg::CLIP_RIGHT_RST;
      clip_bottom_q <= cpsd_pkg::CLIP_BOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpsd_pkg::CFG_FLAT_MODE:   flat_mode_q   <= cfg_wdata_i[0];
        cpsd_pkg::CFG_CENTER_MODE: center_mode_q <= cfg_wdata_i[0];
        cpsd_pkg::CFG_ORIGIN_X:    origin_x_q    <= cfg_wdata_i;
        cpsd_pkg::CFG_ORIGIN_Y:    origin_y_q    <= cfg_wdata_i;
        cpsd_pkg::CFG_PIC_WIDTH:   pic_width_q   <= cfg_wdata_i[8:0];
        cpsd_pkg::CFG_PIC_HEIGHT:  pic_height_q  <= cfg_wdata_i;
        cpsd_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata_i;
        cpsd_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_q;
  cpsd_pkg::in_beat_t in_beat_q;
  logic               advance;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_beat_q <= in_beat_i;
    end
  end

  // origin: fixed or centered (halving truncates toward zero)
  logic signed [15:0] fix_x, fix_y, dif_x, dif_y, rnd_x, rnd_y, ctr_x, ctr_y;

  always_comb begin
    fix_x = {{6{origin_x_q[9]}}, origin_x_q};
    fix_y = {{6{origin_y_q[9]}}, origin_y_q};
    dif_x = Pitch - {7'b0, pic_width_q};
    dif_y = cpsd_pkg::SCREEN_ROWS - {6'b0, pic_height_q};
    rnd_x = dif_x + {15'b0, dif_x[15]};
    rnd_y = dif_y + {15'b0, dif_y[15]};
    ctr_x = {rnd_x[15], rnd_x[15:1]};
    ctr_y = {rnd_y[15], rnd_y[15:1]};
  end

  // decode state
  cpsd_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [9:0]       row_q, row_d;
  logic [7:0]       left_q, left_d;
  logic [ColW-1:0]  fcol_q, fcol_d, fcol_cur;
  logic [RowW-1:0]  frow_q, frow_d, frow_cur;

  logic signed [15:0] sx, sy;
  logic [15:0]        prod;
  logic               hit;
  logic [7:0]         left_dec;

  always_comb begin
    phase_d  = phase_q;
    row_d    = row_q;
    left_d   = left_q;
    fcol_d   = fcol_q;
    frow_d   = frow_q;
    hit      = 1'b0;
    sx       = fix_x;
    sy       = fix_y;
    left_dec = left_q - 8'd1;
    fcol_cur = in_beat_q.first_byte ? '0 : fcol_q;
    frow_cur = in_beat_q.first_byte ? '0 : frow_q;
    phase_cur = in_beat_q.first_byte ? cpsd_pkg::PH_START : phase_q;

    if (flat_mode_q) begin
      sx = fix_x + {{(16-ColW){1'b0}}, fcol_cur};
      sy = fix_y + {{(16-RowW){1'b0}}, frow_cur};
      fcol_d = fcol_cur;
      frow_d = frow_cur;
      if (frow_cur != RowW'(FLAT_SIDE)) begin
        hit = 1'b1;
        if (fcol_cur == ColW'(FLAT_SIDE - 1)) begin
          fcol_d = '0;
          frow_d = frow_cur + 1'b1;
        end else begin
          fcol_d = fcol_cur + 1'b1;
        end
      end
    end else begin
      sx = (center_mode_q ? ctr_x : fix_x) + {7'b0, in_beat_q.column_index};
      sy = (center_mode_q ? ctr_y : fix_y) + {6'b0, row_q};
      phase_d = phase_cur;
      case (phase_cur)
        cpsd_pkg::PH_START: begin
          if (in_beat_q.data_byte == cpsd_pkg::END_MARK) begin
            phase_d = cpsd_pkg::PH_DONE;
          end else begin
            row_d   = {2'b0, in_beat_q.data_byte};
            phase_d = cpsd_pkg::PH_LENGTH;
          end
        end
        cpsd_pkg::PH_LENGTH: begin
          left_d  = in_beat_q.data_byte;
          phase_d = cpsd_pkg::PH_PAD;
        end
        cpsd_pkg::PH_PAD: begin
          phase_d = (left_q != 8'd0) ? cpsd_pkg::PH_DATA : cpsd_pkg::PH_TAIL;
        end
        cpsd_pkg::PH_DATA: begin
          if (sy > $signed({6'b0, clip_bottom_q})) begin
            // bottom clip ends the column, this byte is dropped
            phase_d = cpsd_pkg::PH_DONE;
          end else begin
            row_d  = row_q + 10'd1;
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              phase_d = cpsd_pkg::PH_TAIL;
            end
            hit = !(sx > $signed({6'b0, clip_right_q}));
          end
        end
        cpsd_pkg::PH_TAIL: phase_d = cpsd_pkg::PH_START;
        default: ;
      endcase
    end
    // only the low 16 bits of the address matter
    prod = sy * Pitch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cpsd_pkg::PH_START;
      row_q   <= '0;
      left_q  <= '0;
      fcol_q  <= '0;
      frow_q  <= '0;
    end else if (in_valid_q && advance) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      left_q  <= left_d;
      fcol_q  <= fcol_d;
      frow_q  <= frow_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_valid_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && hit) begin
      out_beat_o.pixel_address <= sx + prod;
      out_beat_o.pixel_color   <= in_beat_q.data_byte;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

  localparam int Pitch      = 320;
  localparam int FlatSide   = 64;
  localparam int ItemTarget = 1350;
  localparam int StuckLimit = 2000;
  localparam int NumFixed   = 6;
  localparam int BurstPhase = 3;

  typedef struct packed {
    logic       flat;
    logic       center;
    logic [9:0] ox;
    logic [9:0] oy;
    logic [8:0] w;
    logic [9:0] h;
    logic [9:0] cr;
    logic [9:0] cb;
  } cfg_set_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [8:0]  col;
    logic        first;
    logic        typed;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  color;
  } dir_row_t;

  // default setting: centered, w = h = 0, so origin is (160, 100)
  localparam dir_row_t DIRECTED [28] = '{
    '{8'd0,   9'd0,   1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd2,   9'd0,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'h55,  9'd0,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'hAA,  9'd0,   1'b0, 1'b1, 1'b1, 16'h7DA0, 8'hAA},
    '{8'h00,  9'd0,   1'b0, 1'b1, 1'b1, 16'h7EE0, 8'h00},
    '{8'h12,  9'd0,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd255, 9'd0,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'h77,  9'd0,   1'b0, 1'b1, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd319, 1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd1,   9'd319, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd319, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'hFF,  9'd319, 1'b0, 1'b1, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd319, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd254, 9'd5,   1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd3,   9'd5,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd5,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'h33,  9'd5,   1'b0, 1'b1, 1'b0, 16'h0,    8'h00},
    '{8'h44,  9'd5,   1'b0, 1'b1, 1'b0, 16'h0,    8'h00},
    '{8'd10,  9'd100, 1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd100, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd100, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd100, 1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd7,   9'd2,   1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd3,   9'd2,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'd0,   9'd2,   1'b0, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'h80,  9'd2,   1'b0, 1'b1, 1'b1, 16'h8662, 8'h80},
    '{8'd255, 9'd2,   1'b1, 1'b0, 1'b0, 16'h0,    8'h00},
    '{8'h01,  9'd2,   1'b0, 1'b1, 1'b0, 16'h0,    8'h00}
  };

  // extremes first: full-size centering, odd sizes, most negative and most
  // positive origins, zero clips, and a flat picture at the far corner
  localparam cfg_set_t FIXED_CFG [NumFixed] = '{
    '{1'b0, 1'b1, 10'd0,   10'd0,   9'd320, 10'd1023, 10'd1023, 10'd1023},
    '{1'b0, 1'b1, 10'd0,   10'd0,   9'd1,   10'd201,  10'd1023, 10'd0},
    '{1'b0, 1'b0, 10'h200, 10'h200, 9'd320, 10'd0,    10'd0,    10'd1023},
    '{1'b1, 1'b0, 10'd511, 10'd511, 9'd0,   10'd0,    10'd320,  10'd200},
    '{1'b0, 1'b0, 10'd511, 10'd511, 9'd0,   10'd0,    10'd1023, 10'd1023},
    '{1'b0, 1'b1, 10'd0,   10'd0,   9'd319, 10'd199,  10'd320,  10'd200}
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  cpsd_pkg::in_beat_t            in_beat_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  cpsd_pkg::out_beat_t           out_beat_o;
  logic                          cfg_we_i    = 1'b0;
  logic [cpsd_pkg::CfgIdxW-1:0]  cfg_idx_i   = cpsd_pkg::CFG_FLAT_MODE;
  logic [cpsd_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  // register shadow
  logic       flat_on   = 1'b0;
  logic       center_on = 1'b1;
  logic [9:0] org_x     = '0;
  logic [9:0] org_y     = '0;
  logic [8:0] pic_w     = '0;
  logic [9:0] pic_h     = '0;
  logic [9:0] clip_r    = cpsd_pkg::CLIP_RIGHT_RST;
  logic [9:0] clip_b    = cpsd_pkg::CLIP_BOT_RST;

  // decoder state
  cpsd_pkg::phase_e post_ph  = cpsd_pkg::PH_START;
  logic [9:0]       row_now  = '0;
  logic [7:0]       left_cnt = '0;
  int               flat_pos = 0;

  cpsd_pkg::out_beat_t pending_writes[$];
  int                  in_gap_pct   = 26;
  int                  out_hold_pct = 26;
  int unsigned         mism         = 0;
  int unsigned         writes_seen  = 0;
  int unsigned         bytes_fed    = 0;
  int unsigned         stuck        = 0;

  column_post_sprite_decoder_core #(
    .SCREEN_PITCH(Pitch),
    .FLAT_SIDE   (FlatSide)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (out_hold_pct != 0) && ($urandom_range(99) < out_hold_pct);
  end

  function automatic logic [15:0] pixel_addr(int x, int y);
    int a;
    a = x + y * Pitch;
    return a[15:0];
  endfunction

  // one stream byte through the decoder; returns 1 with a pixel write
  function automatic bit decode_byte(input cpsd_pkg::in_beat_t b,
                                     output cpsd_pkg::out_beat_t px);
    int ox, oy, sx, sy, fr, fc;
    px = '0;
    ox = int'($signed(org_x));
    oy = int'($signed(org_y));
    if (flat_on) begin
      if (b.first_byte) flat_pos = 0;
      if (flat_pos >= FlatSide * FlatSide) return 1'b0;
      fr = flat_pos / FlatSide;
      fc = flat_pos % FlatSide;
      flat_pos++;
      px.pixel_address = pixel_addr(ox + fc, oy + fr);
      px.pixel_color   = b.data_byte;
      return 1'b1;
    end
    if (b.first_byte) post_ph = cpsd_pkg::PH_START;
    if (center_on) begin
      // signed division truncates toward zero
      ox = (Pitch - int'(pic_w)) / 2;
      oy = (int'(cpsd_pkg::SCREEN_ROWS) - int'(pic_h)) / 2;
    end
    case (post_ph)
      cpsd_pkg::PH_START: begin
        if (b.data_byte == cpsd_pkg::END_MARK) begin
          post_ph = cpsd_pkg::PH_DONE;
        end else begin
          row_now = 10'(b.data_byte);
          post_ph = cpsd_pkg::PH_LENGTH;
        end
      end
      cpsd_pkg::PH_LENGTH: begin
        left_cnt = b.data_byte;
        post_ph  = cpsd_pkg::PH_PAD;
      end
      cpsd_pkg::PH_PAD: post_ph = (left_cnt != 0) ? cpsd_pkg::PH_DATA : cpsd_pkg::PH_TAIL;
      cpsd_pkg::PH_DATA: begin
        sy = oy + int'(row_now);
        sx = ox + int'(b.column_index);
        if (sy > int'(clip_b)) begin
          post_ph = cpsd_pkg::PH_DONE;
        end else begin
          row_now  = row_now + 10'd1;
          left_cnt = left_cnt - 8'd1;
          if (left_cnt == 0) post_ph = cpsd_pkg::PH_TAIL;
          if (sx <= int'(clip_r)) begin
            px.pixel_address = pixel_addr(sx, sy);
            px.pixel_color   = b.data_byte;
            return 1'b1;
          end
        end
      end
      cpsd_pkg::PH_TAIL: post_ph = cpsd_pkg::PH_START;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic cpsd_pkg::in_beat_t mk_beat(int data, int col, bit first);
    cpsd_pkg::in_beat_t b;
    b.data_byte    = data[7:0];
    b.column_index = col[8:0];
    b.first_byte   = first;
    return b;
  endfunction

  function automatic cfg_set_t random_cfg();
    cfg_set_t c;
    c.flat   = ($urandom_range(4) == 0);
    c.center = 1'($urandom_range(1));
    c.ox     = ($urandom_range(2) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(200));
    c.oy     = ($urandom_range(2) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(150));
    c.w      = 9'($urandom_range(320));
    c.h      = ($urandom_range(4) < 3) ? 10'($urandom_range(200)) : 10'($urandom_range(1023));
    c.cr     = $urandom_range(1) ? cpsd_pkg::CLIP_RIGHT_RST : 10'($urandom_range(1023));
    c.cb     = $urandom_range(1) ? cpsd_pkg::CLIP_BOT_RST : 10'($urandom_range(1023));
    return c;
  endfunction

  // typed rows carry their own expectation, the rest use the decoder
  task automatic send_byte(input cpsd_pkg::in_beat_t b, input bit typed = 1'b0,
                           input bit t_wr = 1'b0,
                           input cpsd_pkg::out_beat_t t_px = '0);
    cpsd_pkg::out_beat_t px;
    bit                  wr;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_fed++;
    wr = decode_byte(b, px);
    if (typed) begin
      if (t_wr) pending_writes.push_back(t_px);
    end else if (wr) begin
      pending_writes.push_back(px);
    end
  endtask

  task automatic write_reg(logic [cpsd_pkg::CfgIdxW-1:0] idx,
                           logic [cpsd_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      cpsd_pkg::CFG_FLAT_MODE:   flat_on   = val[0];
      cpsd_pkg::CFG_CENTER_MODE: center_on = val[0];
      cpsd_pkg::CFG_ORIGIN_X:    org_x     = val;
      cpsd_pkg::CFG_ORIGIN_Y:    org_y     = val;
      cpsd_pkg::CFG_PIC_WIDTH:   pic_w     = val[8:0];
      cpsd_pkg::CFG_PIC_HEIGHT:  pic_h     = val;
      cpsd_pkg::CFG_CLIP_RIGHT:  clip_r    = val;
      cpsd_pkg::CFG_CLIP_BOTTOM: clip_b    = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(cfg_set_t c);
    write_reg(cpsd_pkg::CFG_FLAT_MODE,   10'(c.flat));
    write_reg(cpsd_pkg::CFG_CENTER_MODE, 10'(c.center));
    write_reg(cpsd_pkg::CFG_ORIGIN_X,    c.ox);
    write_reg(cpsd_pkg::CFG_ORIGIN_Y,    c.oy);
    write_reg(cpsd_pkg::CFG_PIC_WIDTH,   10'(c.w));
    write_reg(cpsd_pkg::CFG_PIC_HEIGHT,  c.h);
    write_reg(cpsd_pkg::CFG_CLIP_RIGHT,  c.cr);
    write_reg(cpsd_pkg::CFG_CLIP_BOTTOM, c.cb);
    cfg_we_i <= 1'b0;
  endtask

  // bytes that give no write may still be in the pipe: pause past latency
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic send_column(int col);
    cpsd_pkg::in_beat_t seq[$];
    int                 posts;
    int                 len;
    int                 cut;
    posts = $urandom_range(3);
    for (int p = 0; p < posts; p++) begin
      seq.push_back(mk_beat(($urandom_range(3) == 0) ? $urandom_range(254) : $urandom_range(40),
                            col, p == 0));
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = $urandom_range(255);
        default: len = $urandom_range(1, 12);
      endcase
      seq.push_back(mk_beat(len, col, 1'b0));
      seq.push_back(mk_beat($urandom, col, 1'b0));
      repeat (len) seq.push_back(mk_beat($urandom, col, 1'b0));
      seq.push_back(mk_beat($urandom, col, 1'b0));
    end
    seq.push_back(mk_beat(cpsd_pkg::END_MARK, col, posts == 0));
    if ($urandom_range(9) == 0) begin
      // broken column: cut anywhere
      cut = $urandom_range(seq.size() - 1);
      seq = seq[0:cut];
    end else if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) seq.push_back(mk_beat($urandom, col, 1'b0));
    end
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // restart_odds 0: one restart at the head only
  task automatic send_flat_run(int n, int restart_odds);
    for (int k = 0; k < n; k++) begin
      send_byte(mk_beat($urandom, $urandom_range(319),
                        (k == 0) || (restart_odds != 0 && $urandom_range(restart_odds) == 0)));
    end
  endtask

  always @(posedge clk_i) begin
    cpsd_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected pixel write: addr %h color %h",
                   out_beat_o.pixel_address, out_beat_o.pixel_color);
      end else begin
        want = pending_writes.pop_front();
        if (want.pixel_address !== out_beat_o.pixel_address ||
            want.pixel_color !== out_beat_o.pixel_color) begin
          mism++;
          if (mism <= 10)
            $display("pixel write %0d: expected addr %h color %h, got addr %h color %h",
                     writes_seen, want.pixel_address, want.pixel_color,
                     out_beat_o.pixel_address, out_beat_o.pixel_color);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck <= 0;
    end else if (stuck == StuckLimit) begin
      $display("timeout: no beat moved for %0d cycles", StuckLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    cfg_set_t cfg;
    int       phases;
    int       phase_goal;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_byte(mk_beat(DIRECTED[i].data, DIRECTED[i].col, DIRECTED[i].first),
                DIRECTED[i].typed, DIRECTED[i].wr,
                '{pixel_address: DIRECTED[i].addr, pixel_color: DIRECTED[i].color});
    end

    phases = 0;
    while (bytes_fed < ItemTarget) begin
      settle();
      cfg = (phases < NumFixed) ? FIXED_CFG[phases] : random_cfg();
      // the flat corner setting and the last fixed setting run with no gaps or stalls
      in_gap_pct   = (phases == BurstPhase || phases == NumFixed - 1) ? 0 : 26;
      out_hold_pct = in_gap_pct;
      program_regs(cfg);
      phase_goal = bytes_fed + 100;
      // leftover parser state from the previous setting carries over
      repeat ($urandom_range(4)) send_byte(mk_beat($urandom, $urandom_range(319), 1'b0));
      while (bytes_fed < phase_goal) begin
        if (flat_on) begin
          send_flat_run($urandom_range(1, 40), 60);
        end else if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_byte(mk_beat($urandom, $urandom_range(319), $urandom_range(3) == 0));
        end else begin
          send_column(($urandom_range(9) == 0) ? ($urandom_range(1) ? 319 : 0)
                                               : $urandom_range(319));
        end
      end
      phases++;
    end

    settle();
    $display("fed %0d bytes: the directed table, then %0d register settings",
             bytes_fed, phases);
    $display("checked %0d pixel writes, %0d mismatching", writes_seen, mism);
    if (mism == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- column_post_sprite_decoder_core.f -----
rtl/cpsd_pkg.sv
rtl/column_post_sprite_decoder_core.sv
tb/sv/tb_top.sv
